>>> rtl/core/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// Shared widths, codes and types of the separable 3-tap convolution block.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int TAPS       = 3;

  localparam int TAP_W     = 16;
  localparam int DIM_W     = 11;
  localparam int CFG_W     = 16;
  localparam int REG_IDX_W = 3;
  localparam int PIX_W     = 8;
  localparam int VS_W      = 26;
  localparam int FILT_W    = 43;
  localparam int POS_W     = 10;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 4);
  localparam int WD_W  = $clog2(MAX_WIDTH + 1);
  localparam int HT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int LINE_W = 2 * PIX_W;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COL_TAP_0    = 3'd0,
    REG_COL_TAP_1    = 3'd1,
    REG_COL_TAP_2    = 3'd2,
    REG_ROW_TAP_0    = 3'd3,
    REG_ROW_TAP_1    = 3'd4,
    REG_ROW_TAP_2    = 3'd5,
    REG_FRAME_WIDTH  = 3'd6,
    REG_FRAME_HEIGHT = 3'd7
  } scs_reg_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } scs_op_t;

  // Live configuration, geometry already clamped to 1..MAX
  typedef struct packed {
    logic [TAPS-1:0][TAP_W-1:0] col_tap;
    logic [TAPS-1:0][TAP_W-1:0] row_tap;
    logic [WD_W-1:0]            width;
    logic [HT_W-1:0]            height;
  } scs_cfg_t;

endpackage

>>> rtl/core/scs_if.sv
// ----------------------------------------------------------------------------
// scs_if
// Valid/ready channels for pixel beats in and filtered beats out.
// ----------------------------------------------------------------------------
interface scs_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [scs_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output op, output pixel, input ready);
  modport sink   (input valid, input op, input pixel, output ready);
endinterface

interface scs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [scs_pkg::FILT_W-1:0] filtered;
  logic [scs_pkg::POS_W-1:0]         out_row;
  logic [scs_pkg::POS_W-1:0]         out_col;
  logic                              frame_last;

  modport source (output valid, output filtered, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink   (input valid, input filtered, input out_row, input out_col,
                  input frame_last, output ready);
endinterface

>>> rtl/core/scs_ram.sv
// ----------------------------------------------------------------------------
// scs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/scs_cfg_regs.sv
// ----------------------------------------------------------------------------
// scs_cfg_regs
// Tap and geometry registers; clamps the frame size to 1..MAX.
// ----------------------------------------------------------------------------
module scs_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [scs_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [scs_pkg::CFG_W-1:0]         cfg_data,
  output scs_pkg::scs_cfg_t                 cfg
);

  logic [scs_pkg::TAPS-1:0][scs_pkg::TAP_W-1:0] col_tap_r;
  logic [scs_pkg::TAPS-1:0][scs_pkg::TAP_W-1:0] row_tap_r;
  logic [scs_pkg::DIM_W-1:0]                    frame_width_r;
  logic [scs_pkg::DIM_W-1:0]                    frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_tap_r      <= {scs_pkg::TAP_W'(0), scs_pkg::TAP_W'(4096), scs_pkg::TAP_W'(0)};
      row_tap_r      <= {scs_pkg::TAP_W'(0), scs_pkg::TAP_W'(4096), scs_pkg::TAP_W'(0)};
      frame_width_r  <= scs_pkg::DIM_W'(1024);
      frame_height_r <= scs_pkg::DIM_W'(1024);
    end else if (cfg_we) begin
      case (scs_pkg::scs_reg_t'(cfg_index))
        scs_pkg::REG_COL_TAP_0:    col_tap_r[0]   <= cfg_data[scs_pkg::TAP_W-1:0];
        scs_pkg::REG_COL_TAP_1:    col_tap_r[1]   <= cfg_data[scs_pkg::TAP_W-1:0];
        scs_pkg::REG_COL_TAP_2:    col_tap_r[2]   <= cfg_data[scs_pkg::TAP_W-1:0];
        scs_pkg::REG_ROW_TAP_0:    row_tap_r[0]   <= cfg_data[scs_pkg::TAP_W-1:0];
        scs_pkg::REG_ROW_TAP_1:    row_tap_r[1]   <= cfg_data[scs_pkg::TAP_W-1:0];
        scs_pkg::REG_ROW_TAP_2:    row_tap_r[2]   <= cfg_data[scs_pkg::TAP_W-1:0];
        scs_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[scs_pkg::DIM_W-1:0];
        scs_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data[scs_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.col_tap = col_tap_r;
    cfg.row_tap = row_tap_r;
    if (frame_width_r == '0) begin
      cfg.width = scs_pkg::WD_W'(1);
    end else if (int'(frame_width_r) > scs_pkg::MAX_WIDTH) begin
      cfg.width = scs_pkg::WD_W'(scs_pkg::MAX_WIDTH);
    end else begin
      cfg.width = scs_pkg::WD_W'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      cfg.height = scs_pkg::HT_W'(1);
    end else if (int'(frame_height_r) > scs_pkg::MAX_HEIGHT) begin
      cfg.height = scs_pkg::HT_W'(scs_pkg::MAX_HEIGHT);
    end else begin
      cfg.height = scs_pkg::HT_W'(frame_height_r);
    end
  end

endmodule

>>> rtl/core/separable_convolution_3tap.sv
// ----------------------------------------------------------------------------
// separable_convolution_3tap
// Separable 3x3 convolution of a raster pixel stream: vertical taps over two
// line buffers held in one RAM, then horizontal taps over a vertical-sum window.
// ----------------------------------------------------------------------------
// Flow: a beat is taken only in idle, and the next one only when this one is
//   through the line RAM read-modify-write and the horizontal multiply, plus
//   the add when it yields a result; the add waits while the output register is full.
// Output: a result enters the output register from the add step; it belongs
//   to the pixel W+1 beats earlier in the stream.
// Reset: synchronous, active low; taps, geometry, position and window return to
//   their defaults. Line RAM contents are not cleared (rows 0/1 mask them).
module separable_convolution_3tap (
  input  logic                          clk,
  input  logic                          rst_n,
  scs_in_if.sink                        in_ch,
  scs_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [scs_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [scs_pkg::CFG_W-1:0]     cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_VERT,
    S_MUL,
    S_SUM
  } state_t;

  scs_pkg::scs_cfg_t cfg;

  // Configuration registers
  scs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Line RAM: upper line in the high byte, middle line in the low byte
  logic                      ram_we;
  logic [scs_pkg::COL_W-1:0] ram_raddr;
  logic [scs_pkg::LINE_W-1:0] ram_wdata;
  logic [scs_pkg::LINE_W-1:0] ram_rdata;

  // Control state
  state_t                    state_r, state_nxt;
  logic [scs_pkg::ROW_W-1:0] in_row_r, in_row_nxt;
  logic [scs_pkg::COL_W-1:0] in_col_r, in_col_nxt;
  logic signed [scs_pkg::VS_W-1:0] win0_r, win0_nxt;
  logic signed [scs_pkg::VS_W-1:0] win1_r, win1_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // Per-beat payload
  logic [scs_pkg::ROW_W-1:0] pos_row_r, pos_row_nxt;
  logic [scs_pkg::COL_W-1:0] pos_col_r, pos_col_nxt;
  logic [scs_pkg::PIX_W-1:0] x_r, x_nxt;
  logic signed [scs_pkg::VS_W-1:0] h0_r, h0_nxt;
  logic signed [scs_pkg::VS_W-1:0] h1_r, h1_nxt;
  logic signed [scs_pkg::VS_W-1:0] v_r, v_nxt;
  logic                      use0_r, use0_nxt;
  logic                      have_r, have_nxt;
  logic [scs_pkg::POS_W-1:0] orow_r, orow_nxt;
  logic [scs_pkg::POS_W-1:0] ocol_r, ocol_nxt;
  logic                      last_r, last_nxt;
  logic signed [scs_pkg::FILT_W-1:0] p0_r, p0_nxt;
  logic signed [scs_pkg::FILT_W-1:0] p1_r, p1_nxt;
  logic signed [scs_pkg::FILT_W-1:0] p2_r, p2_nxt;
  logic signed [scs_pkg::FILT_W-1:0] filt_r, filt_nxt;
  logic [scs_pkg::POS_W-1:0] out_row_r, out_row_nxt;
  logic [scs_pkg::POS_W-1:0] out_col_r, out_col_nxt;
  logic                      out_last_r, out_last_nxt;

  // Front-end position normalization (accept cycle)
  logic                      col_wrap;
  logic [scs_pkg::ROW_W-1:0] row_a;
  logic [scs_pkg::COL_W-1:0] col_a;
  logic                      restart;
  logic [scs_pkg::ROW_W-1:0] row_n;
  logic [scs_pkg::COL_W-1:0] col_n;
  logic                      in_fire;
  logic                      out_free;

  // Vertical stage
  logic [scs_pkg::PIX_W-1:0] up_c, mid_c;
  logic signed [scs_pkg::VS_W-1:0] vsum_c;
  logic                      col0;
  int                        row_i, orow_i, ocol_i;
  logic [scs_pkg::COL_W:0]   col_inc;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Wrap a stale column or row left over after a geometry change
  always_comb begin
    col_wrap = int'(in_col_r) >= int'(cfg.width);
    row_a    = col_wrap ? in_row_r + scs_pkg::ROW_W'(1) : in_row_r;
    col_a    = col_wrap ? '0 : in_col_r;
    restart  = int'(row_a) > int'(cfg.height) + 1;
    row_n    = restart ? '0 : row_a;
    col_n    = restart ? '0 : col_a;
  end

  assign ram_raddr = col_n;

  // Rows 0 and 1 see zeros above the frame in place of stale RAM data
  assign up_c  = (pos_row_r >= scs_pkg::ROW_W'(2)) ?
                 ram_rdata[scs_pkg::LINE_W-1:scs_pkg::PIX_W] : '0;
  assign mid_c = (pos_row_r >= scs_pkg::ROW_W'(1)) ? ram_rdata[scs_pkg::PIX_W-1:0] : '0;

  assign vsum_c =
      scs_pkg::VS_W'($signed(cfg.col_tap[2])) * scs_pkg::VS_W'($signed({1'b0, up_c}))
    + scs_pkg::VS_W'($signed(cfg.col_tap[1])) * scs_pkg::VS_W'($signed({1'b0, mid_c}))
    + scs_pkg::VS_W'($signed(cfg.col_tap[0])) * scs_pkg::VS_W'($signed({1'b0, x_r}));

  // Shift the line pair: upper takes the old middle, middle takes the new pixel
  assign ram_we    = (state_r == S_VERT);
  assign ram_wdata = {ram_rdata[scs_pkg::PIX_W-1:0], x_r};

  scs_ram #(
    .WIDTH (scs_pkg::LINE_W),
    .DEPTH (scs_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_col_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    in_row_nxt    = in_row_r;
    in_col_nxt    = in_col_r;
    win0_nxt      = win0_r;
    win1_nxt      = win1_r;
    out_valid_nxt = out_valid_r;
    pos_row_nxt   = pos_row_r;
    pos_col_nxt   = pos_col_r;
    x_nxt         = x_r;
    h0_nxt        = h0_r;
    h1_nxt        = h1_r;
    v_nxt         = v_r;
    use0_nxt      = use0_r;
    have_nxt      = have_r;
    orow_nxt      = orow_r;
    ocol_nxt      = ocol_r;
    last_nxt      = last_r;
    p0_nxt        = p0_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    filt_nxt      = filt_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_last_nxt  = out_last_r;

    col0    = (pos_col_r == '0);
    row_i   = int'(pos_row_r);
    orow_i  = col0 ? row_i - 2 : row_i - 1;
    ocol_i  = col0 ? int'(cfg.width) - 1 : int'(pos_col_r) - 1;
    col_inc = {1'b0, pos_col_r} + (scs_pkg::COL_W + 1)'(1);

    // Drop the delivered beat
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          pos_row_nxt = row_n;
          pos_col_nxt = col_n;
          // Drain ticks and pixels past the last row count as zero
          x_nxt = (in_ch.op == scs_pkg::OP_PIXEL && int'(row_n) < int'(cfg.height)) ?
                  in_ch.pixel : '0;
          state_nxt = S_VERT;
        end
      end

      S_VERT: begin
        v_nxt    = vsum_c;
        h0_nxt   = win0_r;
        h1_nxt   = win1_r;
        use0_nxt = !col0;
        // Column 0 closes the previous row: its last column sees zero on the right
        if (col0) begin
          have_nxt = (row_i >= 2) && (row_i - 2 < int'(cfg.height));
          win0_nxt = '0;
        end else begin
          have_nxt = (row_i >= 1) && (row_i - 1 < int'(cfg.height));
          win0_nxt = win1_r;
        end
        win1_nxt = vsum_c;
        orow_nxt = scs_pkg::POS_W'(orow_i);
        ocol_nxt = scs_pkg::POS_W'(ocol_i);
        last_nxt = have_nxt && (orow_i == int'(cfg.height) - 1) &&
                   (ocol_i == int'(cfg.width) - 1);

        // Advance the raster position; restart after the frame's last result
        if (last_nxt) begin
          in_row_nxt = '0;
          in_col_nxt = '0;
        end else if (int'(col_inc) >= int'(cfg.width)) begin
          in_row_nxt = pos_row_r + scs_pkg::ROW_W'(1);
          in_col_nxt = '0;
        end else begin
          in_row_nxt = pos_row_r;
          in_col_nxt = col_inc[scs_pkg::COL_W-1:0];
        end
        state_nxt = S_MUL;
      end

      S_MUL: begin
        p2_nxt = scs_pkg::FILT_W'($signed(cfg.row_tap[2])) * scs_pkg::FILT_W'(h0_r);
        p1_nxt = scs_pkg::FILT_W'($signed(cfg.row_tap[1])) * scs_pkg::FILT_W'(h1_r);
        p0_nxt = use0_r ?
                 scs_pkg::FILT_W'($signed(cfg.row_tap[0])) * scs_pkg::FILT_W'(v_r) : '0;
        state_nxt = have_r ? S_SUM : S_IDLE;
      end

      S_SUM: begin
        // Hold until the output register is free
        if (out_free) begin
          filt_nxt      = p0_r + p1_r + p2_r;
          out_row_nxt   = orow_r;
          out_col_nxt   = ocol_r;
          out_last_nxt  = last_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_row_r    <= '0;
      in_col_r    <= '0;
      win0_r      <= '0;
      win1_r      <= '0;
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_row_r    <= in_row_nxt;
      in_col_r    <= in_col_nxt;
      win0_r      <= win0_nxt;
      win1_r      <= win1_nxt;
      out_valid_r <= out_valid_nxt;
      have_r      <= have_nxt;
    end
    pos_row_r  <= pos_row_nxt;
    pos_col_r  <= pos_col_nxt;
    x_r        <= x_nxt;
    h0_r       <= h0_nxt;
    h1_r       <= h1_nxt;
    v_r        <= v_nxt;
    use0_r     <= use0_nxt;
    orow_r     <= orow_nxt;
    ocol_r     <= ocol_nxt;
    last_r     <= last_nxt;
    p0_r       <= p0_nxt;
    p1_r       <= p1_nxt;
    p2_r       <= p2_nxt;
    filt_r     <= filt_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.filtered   = filt_r;
  assign out_ch.out_row    = out_row_r;
  assign out_ch.out_col    = out_col_r;
  assign out_ch.frame_last = out_last_r;

`ifndef SYNTHESIS
  a_accept_reads_ram: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_VERT)
    else $error("accepted beat did not move to the RAM read-modify-write step");

  a_sum_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM && !out_valid_r) |=> out_valid_r)
    else $error("finished sum not loaded into a free output register");

  a_last_at_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |->
      (out_col_r == scs_pkg::POS_W'(cfg.width - scs_pkg::WD_W'(1))) &&
      (out_row_r == scs_pkg::POS_W'(cfg.height - scs_pkg::HT_W'(1))))
    else $error("frame_last flagged away from the last pixel of the frame");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VERT || state_r == S_MUL) |-> !in_ch.ready)
    else $error("input ready while a beat is still in the line RAM update");
`endif

endmodule

>>> tb/scs_conv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_conv_checker
// Watches the pixel, filtered and register ports of the separable 3x3
// convolution, keeps its own copy of taps, geometry, line history and
// vertical-sum window, and compares every filtered beat in order.
// ----------------------------------------------------------------------------
module scs_conv_checker
  import scs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  scs_in_if                    in_mon,
  scs_out_if                   out_mon,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int unsigned          n_fail,
  output int unsigned          n_waiting,
  output logic                 frame_open
);

  typedef struct {
    longint      filtered;
    int unsigned row;
    int unsigned col;
    bit          last;
  } filt_beat_t;

  logic signed [TAP_W-1:0] vtap [TAPS];
  logic signed [TAP_W-1:0] htap [TAPS];
  logic [DIM_W-1:0]        geo_w;
  logic [DIM_W-1:0]        geo_h;

  logic [PIX_W-1:0] line_older [MAX_WIDTH];
  logic [PIX_W-1:0] line_newer [MAX_WIDTH];
  longint           vsum_prev;
  longint           vsum_cur;
  int unsigned      at_row;
  int unsigned      at_col;

  filt_beat_t  filt_due [$];
  filt_beat_t  want;
  int unsigned fail_cnt = 0;

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  // Advance the filter by one accepted beat; queue the filtered pixel it yields.
  task automatic convolve_beat(input logic op, input logic [PIX_W-1:0] pix);
    int unsigned w, h, c, orow, ocol;
    longint      x, up, mid, v, acc;
    bit          have;
    filt_beat_t  beat;
    w = clamp_dim(geo_w, MAX_WIDTH);
    h = clamp_dim(geo_h, MAX_HEIGHT);
    have = 1'b0;
    acc = 0;
    orow = 0;
    ocol = 0;
    if (at_col >= w) begin
      at_col = 0;
      at_row++;
    end
    if (at_row > h + 1) begin
      at_row = 0;
      at_col = 0;
    end
    c = at_col % MAX_WIDTH;
    // rows past the frame and drain beats feed zeros
    x   = (op == OP_PIXEL && at_row < h) ? longint'(pix) : 0;
    up  = (at_row >= 2) ? longint'(line_older[c]) : 0;
    mid = (at_row >= 1) ? longint'(line_newer[c]) : 0;
    v = longint'(vtap[2]) * up + longint'(vtap[1]) * mid + longint'(vtap[0]) * x;
    line_older[c] = line_newer[c];
    line_newer[c] = PIX_W'(x);

    if (at_col == 0) begin
      // last column of the row two back; its right neighbor is outside
      if (at_row >= 2 && at_row - 2 < h) begin
        have = 1'b1;
        orow = at_row - 2;
        ocol = w - 1;
        acc  = longint'(htap[2]) * vsum_prev + longint'(htap[1]) * vsum_cur;
      end
      vsum_prev = 0;
      vsum_cur  = v;
    end else begin
      if (at_row >= 1 && at_row - 1 < h) begin
        have = 1'b1;
        orow = at_row - 1;
        ocol = at_col - 1;
        acc  = longint'(htap[2]) * vsum_prev + longint'(htap[1]) * vsum_cur
             + longint'(htap[0]) * v;
      end
      vsum_prev = vsum_cur;
      vsum_cur  = v;
    end

    at_col++;
    if (at_col >= w) begin
      at_col = 0;
      at_row++;
    end

    if (have) begin
      beat.filtered = acc;
      beat.row      = orow & 32'h3FF;
      beat.col      = ocol & 32'h3FF;
      beat.last     = (orow == h - 1) && (ocol == w - 1);
      filt_due      = {filt_due, beat};
      if (beat.last) begin
        at_row = 0;
        at_col = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      vtap      = '{16'sd0, 16'sd4096, 16'sd0};
      htap      = '{16'sd0, 16'sd4096, 16'sd0};
      geo_w     = DIM_W'(MAX_WIDTH);
      geo_h     = DIM_W'(MAX_HEIGHT);
      vsum_prev = 0;
      vsum_cur  = 0;
      at_row    = 0;
      at_col    = 0;
      filt_due.delete();
    end else begin
      if (cfg_we) begin
        case (scs_reg_t'(cfg_index))
          REG_COL_TAP_0:    vtap[0] = cfg_data[TAP_W-1:0];
          REG_COL_TAP_1:    vtap[1] = cfg_data[TAP_W-1:0];
          REG_COL_TAP_2:    vtap[2] = cfg_data[TAP_W-1:0];
          REG_ROW_TAP_0:    htap[0] = cfg_data[TAP_W-1:0];
          REG_ROW_TAP_1:    htap[1] = cfg_data[TAP_W-1:0];
          REG_ROW_TAP_2:    htap[2] = cfg_data[TAP_W-1:0];
          REG_FRAME_WIDTH:  geo_w   = cfg_data[DIM_W-1:0];
          REG_FRAME_HEIGHT: geo_h   = cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) convolve_beat(in_mon.op, in_mon.pixel);
      if (out_mon.valid && out_mon.ready) begin
        if (filt_due.size() == 0) begin
          $error("filtered beat with none expected (row %0d col %0d)",
                 out_mon.out_row, out_mon.out_col);
          fail_cnt++;
        end else begin
          want = filt_due.pop_front();
          check_field("filtered", want.filtered, longint'(out_mon.filtered));
          check_field("out_row", want.row, longint'(out_mon.out_row));
          check_field("out_col", want.col, longint'(out_mon.out_col));
          check_field("frame_last", want.last, longint'(out_mon.frame_last));
        end
      end
    end
    n_waiting  <= filt_due.size();
    frame_open <= (at_row != 0) || (at_col != 0);
    n_fail     <= fail_cnt;
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the separable 3x3 convolution: short directed frames covering
// extreme taps, degenerate geometry, drain and stray beats and a
// geometry change in mid-frame, then random frames with random kernels, then
// one full-height frame with a saturated height. A checker beside the block
// predicts and compares every filtered beat; this module only drives and gives
// the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import scs_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  scs_in_if  in_bus ();
  scs_out_if out_bus ();

  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int unsigned n_fail;
  int unsigned n_waiting;
  logic        frame_open;

  // Throttle control: calm switches all random idling off on both sides.
  logic        calm = 1'b0;
  int unsigned n_beats = 0;

  // Register image that the next apply_config() writes.
  logic [TAP_W-1:0] col_set [TAPS];
  logic [TAP_W-1:0] row_set [TAPS];
  logic [DIM_W-1:0] w_set;
  logic [DIM_W-1:0] h_set;

  // First directed frame, 4 x 3; beat 5 goes out as a drain inside the frame.
  logic [PIX_W-1:0] demo_px [12] = '{8'd255, 8'd255, 8'd0,   8'd255,
                                     8'd0,   8'd77,  8'd255, 8'd128,
                                     8'd1,   8'd254, 8'd255, 8'd0};

  always #5 clk = ~clk;

  separable_convolution_3tap u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  scs_conv_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .n_fail     (n_fail),
    .n_waiting  (n_waiting),
    .frame_open (frame_open)
  );

  // Sink side: stall about 15% of cycles unless in the calm stretch.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_bus.ready <= calm || ($urandom_range(0, 99) >= 15);
    end
  end

  // Hard stop in case the block hangs or drops a beat.
  initial begin
    #3ms;
    $display("FAILURE");
    $finish;
  end

  // Effective frame size as the block sees it: zero means one, too big saturates.
  function automatic int unsigned frame_dim(input logic [DIM_W-1:0] raw, input int unsigned lim);
    if (raw == 0) return 1;
    if (raw > lim) return lim;
    return raw;
  endfunction

  // Tap values weighted toward the extremes and unity gain.
  function automatic logic [TAP_W-1:0] rand_tap();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'h1000;
      4:       return 16'hF000;
      default: return TAP_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic pick_kernels();
    for (int i = 0; i < TAPS; i++) begin
      col_set[i] = rand_tap();
      row_set[i] = rand_tap();
    end
  endtask

  // One register write per clock; the caller drops the write enable.
  task automatic write_reg(input scs_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Write the whole register image; only called while the block is idle.
  task automatic apply_config();
    write_reg(REG_COL_TAP_0, col_set[0]);
    write_reg(REG_COL_TAP_1, col_set[1]);
    write_reg(REG_COL_TAP_2, col_set[2]);
    write_reg(REG_ROW_TAP_0, row_set[0]);
    write_reg(REG_ROW_TAP_1, row_set[1]);
    write_reg(REG_ROW_TAP_2, row_set[2]);
    write_reg(REG_FRAME_WIDTH, CFG_W'(w_set));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(h_set));
    cfg_we <= 1'b0;
  endtask

  // Present one beat and hold it until the block takes it. Random idle cycles
  // go in ahead of the beat, except during the calm stretch.
  task automatic send_beat(input scs_op_t op, input logic [PIX_W-1:0] pix);
    calm = (n_beats >= 700) && (n_beats < 1100);
    while (!calm && $urandom_range(0, 99) < 15) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.op    <= op;
    in_bus.pixel <= pix;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    n_beats++;
  endtask

  // Drop valid and wait until every predicted beat has come back, then give
  // the block time to finish a beat that yields no output.
  task automatic quiesce();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (n_waiting != 0);
    repeat (10) @(posedge clk);
  endtask

  // A well-formed frame with some noise: the odd drain beat inside the frame,
  // and the odd pixel beat among the W+1 trailing drain beats.
  task automatic send_frame();
    int unsigned w, h;
    w = frame_dim(w_set, MAX_WIDTH);
    h = frame_dim(h_set, MAX_HEIGHT);
    for (int unsigned i = 0; i < w * h; i++)
      send_beat(($urandom_range(0, 19) == 0) ? OP_DRAIN : OP_PIXEL, rand_pixel());
    for (int unsigned i = 0; i <= w; i++)
      send_beat(($urandom_range(0, 4) == 0) ? OP_PIXEL : OP_DRAIN, rand_pixel());
  endtask

  // Feed beats one at a time until the frame in progress has closed. The
  // checker's frame state is updated at the same edge that accepts each beat.
  task automatic finish_frame();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (frame_open) begin
      send_beat(scs_op_t'($urandom_range(0, 1)), rand_pixel());
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop partway through a frame, then narrow the width (never widen it, so no
  // line-buffer column is read before it is written) and move the height.
  task automatic split_frame();
    int unsigned w, h, cut;
    w = frame_dim(w_set, MAX_WIDTH);
    h = frame_dim(h_set, MAX_HEIGHT);
    cut = $urandom_range(1, w * h - 1);
    for (int unsigned i = 0; i < cut; i++) send_beat(OP_PIXEL, rand_pixel());
    quiesce();
    w_set = DIM_W'($urandom_range(1, w));
    h_set = DIM_W'($urandom_range(0, h + 2));
    if ($urandom_range(0, 1) == 1) pick_kernels();
    apply_config();
    finish_frame();
  endtask

  initial begin
    int unsigned goal;
    in_bus.valid = 1'b0;
    in_bus.op    = OP_PIXEL;
    in_bus.pixel = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_COL_TAP_0;
    cfg_data     = '0;
    rst_n        = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extreme taps of both signs, 4 x 3 frame: full-scale pixels, a drain beat
    // inside the frame and a stray pixel beat among the trailing drains.
    col_set = '{16'h8000, 16'h7FFF, 16'h8000};
    row_set = '{16'h7FFF, 16'h8000, 16'h7FFF};
    w_set = 4;
    h_set = 3;
    apply_config();
    for (int i = 0; i < 12; i++) send_beat((i == 5) ? OP_DRAIN : OP_PIXEL, demo_px[i]);
    for (int i = 0; i < 5; i++) send_beat((i == 1) ? OP_PIXEL : OP_DRAIN, 8'hFF);
    quiesce();

    // Zero width and height both act as one: a single-pixel frame.
    pick_kernels();
    w_set = 0;
    h_set = 0;
    apply_config();
    send_beat(OP_PIXEL, 8'd200);
    send_beat(OP_DRAIN, 8'd0);
    send_beat(OP_DRAIN, 8'd0);
    quiesce();

    // Identity kernel, 5 x 4 frame cut after eight pixels; the narrower width
    // pushes the next beat to a new row and the short height ends the frame.
    col_set = '{16'h0000, 16'h1000, 16'h0000};
    row_set = '{16'h0000, 16'h1000, 16'h0000};
    w_set = 5;
    h_set = 4;
    apply_config();
    for (int i = 0; i < 8; i++) send_beat(OP_PIXEL, rand_pixel());
    quiesce();
    w_set = 2;
    h_set = 1;
    apply_config();
    finish_frame();
    quiesce();

    // Random kernels and small geometry, one to three frames per setting.
    goal = n_beats + 700;
    while (n_beats < goal) begin
      pick_kernels();
      case ($urandom_range(0, 9))
        0:       w_set = 0;
        1:       w_set = 3;
        2, 3:    w_set = DIM_W'($urandom_range(11, 40));
        default: w_set = DIM_W'($urandom_range(1, 10));
      endcase
      h_set = ($urandom_range(0, 9) == 0) ? '0 : DIM_W'($urandom_range(1, 8));
      apply_config();
      repeat ($urandom_range(1, 3)) begin
        if (frame_dim(w_set, MAX_WIDTH) * frame_dim(h_set, MAX_HEIGHT) >= 2 &&
            $urandom_range(0, 4) == 0)
          split_frame();
        else
          send_frame();
      end
      quiesce();
    end

    // Largest height: one column, and a height above the maximum saturates to
    // the full 1024 rows.
    pick_kernels();
    w_set = DIM_W'(1);
    h_set = DIM_W'(2047);
    apply_config();
    send_frame();
    quiesce();

    if (n_fail == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
